// ===== hw/rtl/csem_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csem_pkg
// Shared types, sizes and helpers of the counting semaphore table.
// ---------------------------------------------------------------------------
package csem_pkg;

  // table geometry
  localparam int NUM_SEMS        = 32;
  localparam int WAITERS_PER_SEM = 64;
  localparam int SLOT_DEPTH      = NUM_SEMS * WAITERS_PER_SEM;

  // field widths
  localparam int REQ_TYPE_W = 2;
  localparam int SEM_ID_W   = 6;
  localparam int VALUE_W    = 16;
  localparam int PID_W      = 16;
  localparam int HANDLE_W   = 5;
  localparam int COUNT_W    = 18;

  // derived index widths
  localparam int ID_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int SLOT_W  = (WAITERS_PER_SEM > 1) ? $clog2(WAITERS_PER_SEM) : 1;
  localparam int ADDR_W  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int IDX_W   = (ID_W > SLOT_W) ? ID_W : SLOT_W;
  localparam int CNT_W   = IDX_W + 1;

  // count limits
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_WAIT    = 2'd2,
    REQ_SIGNAL  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    MODE_CREATE,
    MODE_FIND_EMPTY,
    MODE_FIND_USED
  } mode_e;

  // one waiter slot
  typedef struct packed {
    logic             vld;
    logic [PID_W-1:0] pid;
  } slot_t;

  // scan unit control and status
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] limit;
  } scan_ctl_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] chk_idx;
    logic             found;
    logic             exhausted;
  } scan_sts_t;

  // flat waiter store address of a slot within an entry's row
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [ID_W-1:0]   entry,
                                                  input logic [SLOT_W-1:0] slot);
    int unsigned a;
    a = int'(entry) * WAITERS_PER_SEM + int'(slot);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/csem_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csem_req_if
// Request channel: valid/ready handshake with the request payload.
// ---------------------------------------------------------------------------
interface csem_req_if;
  import csem_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [SEM_ID_W-1:0]   sem_id;
  logic [VALUE_W-1:0]    initial_value;
  logic [PID_W-1:0]      caller_pid;

  modport source (output valid, req_type, sem_id, initial_value, caller_pid, input ready);
  modport sink   (input valid, req_type, sem_id, initial_value, caller_pid, output ready);
endinterface

// ===== hw/rtl/csem_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csem_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ---------------------------------------------------------------------------
interface csem_rsp_if;
  import csem_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [HANDLE_W-1:0] new_handle;
  logic                must_block;
  logic                wake_valid;
  logic [PID_W-1:0]    wake_pid;

  modport source (output valid, status, new_handle, must_block, wake_valid, wake_pid,
                  input ready);
  modport sink   (input valid, status, new_handle, must_block, wake_valid, wake_pid,
                  output ready);
endinterface

// ===== hw/rtl/csem_slot_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csem_slot_mem
// Waiter slot store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module csem_slot_mem
  import csem_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  slot_t             wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output slot_t             rdata_o
);

  slot_t mem_q [SLOT_DEPTH];
  slot_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/csem_scan.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csem_scan
// Shared scan unit: walks indices from zero, one read issued per cycle,
// and stops at the first element the caller flags as a hit.
// ---------------------------------------------------------------------------
module csem_scan
  import csem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  input  logic      hit_i,
  output scan_sts_t sts_o
);

  logic             active_q, active_d;
  logic             chk_vld_q, chk_vld_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [IDX_W-1:0] chk_q, chk_d;
  logic             issue;
  logic             found;
  logic             exhausted;

  // issue, hit and end detection
  always_comb begin
    issue     = active_q && (rd_q < ctl_i.limit);
    found     = active_q && chk_vld_q && hit_i;
    exhausted = active_q && !chk_vld_q && !issue;
  end

  // counter and check stage next values
  always_comb begin
    active_d  = active_q;
    chk_vld_d = chk_vld_q;
    rd_d      = rd_q;
    chk_d     = chk_q;
    if (ctl_i.start) begin
      active_d  = 1'b1;
      chk_vld_d = 1'b0;
      rd_d      = '0;
    end else if (active_q) begin
      if (found || exhausted) begin
        active_d  = 1'b0;
        chk_vld_d = 1'b0;
      end else begin
        chk_vld_d = issue;
        chk_d     = rd_q[IDX_W-1:0];
        if (issue) begin
          rd_d = rd_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      chk_vld_q <= 1'b0;
      rd_q      <= '0;
      chk_q     <= '0;
    end else begin
      active_q  <= active_d;
      chk_vld_q <= chk_vld_d;
      rd_q      <= rd_d;
      chk_q     <= chk_d;
    end
  end

  assign sts_o.rd_en     = issue;
  assign sts_o.rd_idx    = rd_q[IDX_W-1:0];
  assign sts_o.chk_idx   = chk_q;
  assign sts_o.found     = found;
  assign sts_o.exhausted = exhausted;

endmodule

// ===== hw/rtl/counting_semaphore_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with a fixed list of waiter slots per entry.
// ---------------------------------------------------------------------------
//  port    dir  handshake     payload
//  req_i   in   valid/ready   req_type, sem_id, initial_value, caller_pid
//  rsp_o   out  valid/ready   status, new_handle, must_block, wake_valid, wake_pid
//
//  One request at a time. Destroy, an out-of-range id, and wait or signal
//  that need no slot search go from the execute state to the response state.
//  Create scans the in-use marks one entry per cycle, up to NUM_SEMS entries.
//  Wait and signal with a slot search read one slot per cycle from the
//  slot store read port, up to WAITERS_PER_SEM slots per search.
//  After reset a clearing pass empties the slot store, one slot per cycle
//  (NUM_SEMS * WAITERS_PER_SEM = 2048 slots), before req_i goes ready.
//  A stalled result holds the block in its response state.
// ---------------------------------------------------------------------------
module counting_semaphore_table
  import csem_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  csem_req_if.sink   req_i,
  csem_rsp_if.source rsp_o
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  // latched request
  req_e               req_q;
  logic               id_ok_q;
  logic [ID_W-1:0]    entry_q;
  logic [VALUE_W-1:0] init_q;
  logic [PID_W-1:0]   pid_q;

  // semaphore table
  logic signed [COUNT_W-1:0] cnt_q [NUM_SEMS];
  logic [NUM_SEMS-1:0]       inuse_q;
  logic                      inuse_rd_q;

  // clearing pass counter
  logic [ADDR_W-1:0] clr_q, clr_d;

  // result registers
  logic                status_q, status_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                block_q, block_d;
  logic                wvalid_q, wvalid_d;
  logic [PID_W-1:0]    wpid_q, wpid_d;

  // table update controls
  logic                      cnt_we;
  logic [ID_W-1:0]           cnt_widx;
  logic signed [COUNT_W-1:0] cnt_wdata;
  logic                      inuse_set;
  logic                      inuse_clr;
  logic [ID_W-1:0]           inuse_idx;

  // slot store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  slot_t             mem_rdata;

  // scan unit
  scan_ctl_t scan_ctl;
  scan_sts_t scan_sts;
  logic      scan_hit;

  logic                      req_xfer;
  logic signed [COUNT_W-1:0] cnt_old;
  logic signed [COUNT_W-1:0] cnt_dec;
  logic signed [COUNT_W-1:0] cnt_inc;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  // count arithmetic with saturation at both ends
  always_comb begin
    cnt_old = cnt_q[entry_q];
    cnt_dec = (cnt_old != COUNT_MIN) ? (cnt_old - COUNT_W'(1)) : cnt_old;
    cnt_inc = (cnt_old != COUNT_MAX) ? (cnt_old + COUNT_W'(1)) : cnt_old;
  end

  // hit qualifier for the element under check
  always_comb begin
    unique case (mode_q)
      MODE_CREATE:     scan_hit = !inuse_rd_q;
      MODE_FIND_EMPTY: scan_hit = !mem_rdata.vld;
      MODE_FIND_USED:  scan_hit = mem_rdata.vld;
      default:         scan_hit = 1'b0;
    endcase
  end

  // slot store read side follows the scan unit
  assign mem_re    = (state_q == ST_SCAN) && (mode_q != MODE_CREATE) && scan_sts.rd_en;
  assign mem_raddr = slot_addr(entry_q, scan_sts.rd_idx[SLOT_W-1:0]);

  // sequencer: next state, table updates and result
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    clr_d     = clr_q;
    status_d  = status_q;
    handle_d  = handle_q;
    block_d   = block_q;
    wvalid_d  = wvalid_q;
    wpid_d    = wpid_q;
    cnt_we    = 1'b0;
    cnt_widx  = entry_q;
    cnt_wdata = cnt_old;
    inuse_set = 1'b0;
    inuse_clr = 1'b0;
    inuse_idx = entry_q;
    mem_we    = 1'b0;
    mem_waddr = slot_addr(entry_q, scan_sts.chk_idx[SLOT_W-1:0]);
    mem_wdata = '{vld: 1'b0, pid: '0};
    scan_ctl  = '{start: 1'b0, limit: CNT_W'(WAITERS_PER_SEM)};
    if (mode_q == MODE_CREATE) begin
      scan_ctl.limit = CNT_W'(NUM_SEMS);
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(SLOT_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_xfer) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        status_d = 1'b0;
        handle_d = '0;
        block_d  = 1'b0;
        wvalid_d = 1'b0;
        wpid_d   = '0;
        state_d  = ST_RESP;
        if (req_q == REQ_CREATE) begin
          mode_d         = MODE_CREATE;
          scan_ctl.start = 1'b1;
          scan_ctl.limit = CNT_W'(NUM_SEMS);
          state_d        = ST_SCAN;
        end else if (!id_ok_q) begin
          status_d = 1'b1;
        end else begin
          unique case (req_q)
            REQ_DESTROY: begin
              if (inuse_q[entry_q]) begin
                inuse_clr = 1'b1;
              end else begin
                status_d = 1'b1;
              end
            end
            REQ_WAIT: begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_dec;
              if (cnt_dec[COUNT_W-1]) begin
                block_d        = 1'b1;
                mode_d         = MODE_FIND_EMPTY;
                scan_ctl.start = 1'b1;
                scan_ctl.limit = CNT_W'(WAITERS_PER_SEM);
                state_d        = ST_SCAN;
              end
            end
            REQ_SIGNAL: begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_inc;
              if (cnt_old[COUNT_W-1]) begin
                mode_d         = MODE_FIND_USED;
                scan_ctl.start = 1'b1;
                scan_ctl.limit = CNT_W'(WAITERS_PER_SEM);
                state_d        = ST_SCAN;
              end
            end
            default: begin
              status_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_sts.found) begin
          state_d = ST_RESP;
          unique case (mode_q)
            MODE_CREATE: begin
              inuse_set = 1'b1;
              inuse_idx = scan_sts.chk_idx[ID_W-1:0];
              cnt_we    = 1'b1;
              cnt_widx  = scan_sts.chk_idx[ID_W-1:0];
              cnt_wdata = COUNT_W'(init_q);
              handle_d  = HANDLE_W'(scan_sts.chk_idx);
            end
            MODE_FIND_EMPTY: begin
              mem_we    = 1'b1;
              mem_wdata = '{vld: 1'b1, pid: pid_q};
            end
            MODE_FIND_USED: begin
              mem_we    = 1'b1;
              mem_wdata = '{vld: 1'b0, pid: mem_rdata.pid};
              wvalid_d  = 1'b1;
              wpid_d    = mem_rdata.pid;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end else if (scan_sts.exhausted) begin
          state_d = ST_RESP;
          if (mode_q == MODE_CREATE) begin
            status_d = 1'b1;
          end
        end
      end

      ST_RESP: begin
        if (rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q  <= MODE_CREATE;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      clr_q   <= clr_d;
    end
  end

  // semaphore table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inuse_q <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cnt_we) begin
        cnt_q[cnt_widx] <= cnt_wdata;
      end
      if (inuse_set) begin
        inuse_q[inuse_idx] <= 1'b1;
      end else if (inuse_clr) begin
        inuse_q[inuse_idx] <= 1'b0;
      end
    end
  end

  // request capture, in-use read stage and result payload
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_q   <= req_e'(req_i.req_type);
      id_ok_q <= ({1'b0, req_i.sem_id} < (SEM_ID_W + 1)'(NUM_SEMS));
      entry_q <= req_i.sem_id[ID_W-1:0];
      init_q  <= req_i.initial_value;
      pid_q   <= req_i.caller_pid;
    end
    if (scan_sts.rd_en) begin
      inuse_rd_q <= inuse_q[scan_sts.rd_idx[ID_W-1:0]];
    end
    status_q <= status_d;
    handle_q <= handle_d;
    block_q  <= block_d;
    wvalid_q <= wvalid_d;
    wpid_q   <= wpid_d;
  end

  assign rsp_o.valid      = (state_q == ST_RESP);
  assign rsp_o.status     = status_q;
  assign rsp_o.new_handle = handle_q;
  assign rsp_o.must_block = block_q;
  assign rsp_o.wake_valid = wvalid_q;
  assign rsp_o.wake_pid   = wpid_q;

  csem_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .hit_i  (scan_hit),
    .sts_o  (scan_sts)
  );

  csem_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
